### src/greedy_change_dispenser_macros.svh
`ifndef GREEDY_CHANGE_DISPENSER_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define GCHG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GCHG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gchg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gchg_pkg;

  localparam int SLOT_MAX = 16;
  localparam int IDX_W    = 4;
  localparam int AMT_W    = 27;
  localparam int CNT_W    = 10;
  localparam int DENOM_W  = 18;
  localparam int QUO_W    = 10;
  localparam int PROD_W   = CNT_W + DENOM_W;

  // request into the shared quotient unit
  typedef struct packed {
    logic               start;
    logic [AMT_W-1:0]   dividend;
    logic [DENOM_W-1:0] divisor;
  } quo_req_t;

  // answer from the quotient unit, quotient saturates at all ones
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } quo_rsp_t;

  // denomination value in cents, unused slots are worth nothing
  function automatic logic [DENOM_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
    logic [DENOM_W-1:0] v;
    case (idx)
      4'd0:    v = 18'd200000;
      4'd1:    v = 18'd100000;
      4'd2:    v = 18'd50000;
      4'd3:    v = 18'd20000;
      4'd4:    v = 18'd10000;
      4'd5:    v = 18'd5000;
      4'd6:    v = 18'd2500;
      4'd7:    v = 18'd2000;
      4'd8:    v = 18'd1000;
      4'd9:    v = 18'd500;
      4'd10:   v = 18'd100;
      4'd11:   v = 18'd50;
      4'd12:   v = 18'd20;
      4'd13:   v = 18'd5;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // full stock level of each denomination
  function automatic logic [CNT_W-1:0] full_level(input logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] v;
    case (idx)
      4'd0:    v = 10'd25;
      4'd1:    v = 10'd30;
      4'd2:    v = 10'd40;
      4'd3:    v = 10'd50;
      4'd4:    v = 10'd60;
      4'd5:    v = 10'd70;
      4'd6:    v = 10'd80;
      4'd7:    v = 10'd90;
      4'd8:    v = 10'd100;
      4'd9:    v = 10'd200;
      4'd10:   v = 10'd300;
      4'd11:   v = 10'd500;
      4'd12:   v = 10'd500;
      4'd13:   v = 10'd500;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/gchg_quot.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle, result clipped to all ones
module gchg_quot (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gchg_pkg::quo_req_t req,
  output gchg_pkg::quo_rsp_t      rsp
);

  localparam int SH_W = gchg_pkg::AMT_W + 1;

  logic                            busy_r;
  logic                            done_r;
  logic [gchg_pkg::AMT_W-1:0]      part_r;
  logic [gchg_pkg::QUO_W-1:0]      quo_r;
  logic [3:0]                      bit_r;

  logic [SH_W-1:0] sat_limit;
  logic [SH_W-1:0] trial;
  logic [SH_W-1:0] part_ext;
  logic            fits;

  // limit beyond which the quotient no longer fits the count width
  assign sat_limit = {{(SH_W-gchg_pkg::DENOM_W){1'b0}}, req.divisor} << gchg_pkg::QUO_W;
  assign trial     = {{(SH_W-gchg_pkg::DENOM_W){1'b0}}, req.divisor} << bit_r;
  assign part_ext  = {1'b0, part_r};
  assign fits      = part_ext >= trial;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        if ({1'b0, req.dividend} >= sat_limit) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          done_r <= 1'b0;
        end
      end else if (busy_r && bit_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // shared compare and subtract, one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      part_r <= req.dividend;
      bit_r  <= 4'(gchg_pkg::QUO_W - 1);
      if ({1'b0, req.dividend} >= sat_limit) begin
        quo_r <= '1;
      end else begin
        quo_r <= '0;
      end
    end else if (busy_r) begin
      if (fits) begin
        part_r       <= gchg_pkg::AMT_W'(part_ext - trial);
        quo_r[bit_r] <= 1'b1;
      end
      if (bit_r != 4'd0) begin
        bit_r <= bit_r - 4'd1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

### src/greedy_change_dispenser.sv
`timescale 1ns / 1ps
`default_nettype none

// Greedy change dispenser with a limited stock of each denomination. A dispense
// transaction (in_mode 0) walks the denominations from 2000 rupees down to 5 cents
// and gives one result transaction per denomination: pieces given, pieces left
// and the amount still owed; out_last marks the final one, whose residual is what
// could not be paid. A refill transaction (in_mode 1) restores every stock to its
// full level and reports each denomination with nothing given and no residual.
// One input transaction is handled at a time and in_stall stays high until its
// last result has been handed to the output register. Each denomination goes through
// issue, the shared restoring divider that finds one quotient bit per cycle, the
// clip of the quotient to the stock, multiply and write-back; a denomination whose
// quotient would not fit ten bits skips the divider loop. Write-back waits while the
// output is stalled.
`include "greedy_change_dispenser_macros.svh"

module greedy_change_dispenser #(
  parameter int NUM_DENOMS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic [gchg_pkg::AMT_W-1:0]    in_amount_cents,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gchg_pkg::IDX_W-1:0]         out_denom_index,
  output logic [gchg_pkg::CNT_W-1:0]         out_given_count,
  output logic [gchg_pkg::CNT_W-1:0]         out_stock_left,
  output logic [gchg_pkg::AMT_W-1:0]         out_residual_cents,
  output logic                               out_last
);

  localparam logic [gchg_pkg::IDX_W-1:0] LAST_IDX = gchg_pkg::IDX_W'(NUM_DENOMS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [gchg_pkg::IDX_W-1:0]     idx_r;
  logic [gchg_pkg::AMT_W-1:0]     rem_r;
  logic [gchg_pkg::CNT_W-1:0]     given_r;
  logic [gchg_pkg::PROD_W-1:0]    prod_r;
  logic [gchg_pkg::CNT_W-1:0]     stock_r [gchg_pkg::SLOT_MAX];

  logic                           out_valid_r;
  logic [gchg_pkg::IDX_W-1:0]     out_idx_r;
  logic [gchg_pkg::CNT_W-1:0]     out_given_r;
  logic [gchg_pkg::CNT_W-1:0]     out_stock_r;
  logic [gchg_pkg::AMT_W-1:0]     out_rem_r;
  logic                           out_last_r;

  gchg_pkg::quo_req_t             div_req;
  gchg_pkg::quo_rsp_t             div_rsp;

  logic                           in_accept;
  logic                           slot_free;
  logic                           emit;
  logic                           is_last;
  logic [gchg_pkg::DENOM_W-1:0]   cur_val;
  logic [gchg_pkg::CNT_W-1:0]     cur_stock;
  logic [gchg_pkg::CNT_W-1:0]     stock_after;
  logic [gchg_pkg::AMT_W-1:0]     rem_after;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_EMIT) && slot_free;
  assign is_last   = (idx_r == LAST_IDX);
  assign cur_val   = gchg_pkg::denom_value(idx_r);
  assign cur_stock = stock_r[idx_r];

  assign stock_after = cur_stock - given_r;
  assign rem_after   = rem_r - gchg_pkg::AMT_W'(prod_r);

  // shared divider
  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = rem_r;
  assign div_req.divisor  = cur_val;

  gchg_quot u_quot (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (div_rsp.done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = is_last ? ST_IDLE : ST_START;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // running remainder, denomination index, pieces and their value
  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx_r <= '0;
      rem_r <= in_mode ? '0 : in_amount_cents;
    end else if (emit) begin
      idx_r <= idx_r + 1'b1;
      rem_r <= rem_after;
    end
    if (state_r == ST_WAIT && div_rsp.done) begin
      given_r <= (div_rsp.quo < cur_stock) ? div_rsp.quo : cur_stock;
    end
    if (state_r == ST_MUL) begin
      prod_r <= given_r * cur_val;
    end
  end

  // coin stock, full at reset and on refill
  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_mode)) begin
      for (int i = 0; i < gchg_pkg::SLOT_MAX; i++) begin
        stock_r[i] <= gchg_pkg::full_level(gchg_pkg::IDX_W'(i));
      end
    end else if (emit) begin
      stock_r[idx_r] <= stock_after;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r   <= idx_r;
      out_given_r <= given_r;
      out_stock_r <= stock_after;
      out_rem_r   <= rem_after;
      out_last_r  <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_denom_index    = out_idx_r;
  assign out_given_count    = out_given_r;
  assign out_stock_left     = out_stock_r;
  assign out_residual_cents = out_rem_r;
  assign out_last           = out_last_r;

  // checks
  `GCHG_ASSERT_NOW(a_given_in_stock, state_r == ST_EMIT, given_r <= cur_stock,
    "pieces given exceed stock")
  `GCHG_ASSERT_NOW(a_prod_in_rem, state_r == ST_EMIT,
    prod_r <= {{(gchg_pkg::PROD_W-gchg_pkg::AMT_W){1'b0}}, rem_r},
    "value given exceeds remainder")
  `GCHG_ASSERT_NOW(a_done_when_waiting, div_rsp.done, state_r == ST_WAIT,
    "divider finished outside wait")
  `GCHG_ASSERT_NEXT(a_accept_starts, in_accept, state_r == ST_START && idx_r == '0,
    "accepted transaction did not start at the first denomination")

endmodule

`default_nettype wire

### test/greedy_change_dispenser_test.sv
`timescale 1ns / 1ps

module greedy_change_dispenser_test;

  localparam int IDX_W = gchg_pkg::IDX_W;
  localparam int CNT_W = gchg_pkg::CNT_W;
  localparam int AMT_W = gchg_pkg::AMT_W;

  localparam int DENOMS      = 14;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_WAIT = 400;
  localparam int PRINT_LIMIT = 100;

  localparam logic MODE_DISPENSE = 1'b0;
  localparam logic MODE_REFILL   = 1'b1;

  // one denomination line of the change breakdown
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] given;
    logic [CNT_W-1:0] left;
    logic [AMT_W-1:0] residual;
    logic             last;
  } change_line_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_mode = MODE_DISPENSE;
  logic [AMT_W-1:0] in_amount_cents = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_denom_index;
  logic [CNT_W-1:0] out_given_count;
  logic [CNT_W-1:0] out_stock_left;
  logic [AMT_W-1:0] out_residual_cents;
  logic             out_last;

  // coin values in cents, largest first, and their full stock levels
  int unsigned coin_cents [DENOMS] = '{200000, 100000, 50000, 20000, 10000, 5000, 2500,
                                       2000, 1000, 500, 100, 50, 20, 5};
  int unsigned full_stock [DENOMS] = '{25, 30, 40, 50, 60, 70, 80, 90, 100, 200, 300,
                                       500, 500, 500};

  logic [CNT_W-1:0] drawer_stock [DENOMS];
  change_line_t     expected_lines [$];
  change_line_t     want_line;

  int error_count   = 0;
  int lines_checked = 0;
  int cycle_count   = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  greedy_change_dispenser #(
    .NUM_DENOMS(DENOMS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_amount_cents   (in_amount_cents),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_denom_index   (out_denom_index),
    .out_given_count   (out_given_count),
    .out_stock_left    (out_stock_left),
    .out_residual_cents(out_residual_cents),
    .out_last          (out_last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch at line %0d: %s got %0d expected %0d", lines_checked, what, got,
               want);
    error_count++;
  endtask

  // compare each result transaction with the oldest expected line
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected result, denom", out_denom_index, -1);
      end else begin
        want_line = expected_lines.pop_front();
        if (out_denom_index !== want_line.idx)
          report_mismatch("denom_index", out_denom_index, want_line.idx);
        if (out_given_count !== want_line.given)
          report_mismatch("given_count", out_given_count, want_line.given);
        if (out_stock_left !== want_line.left)
          report_mismatch("stock_left", out_stock_left, want_line.left);
        if (out_residual_cents !== want_line.residual)
          report_mismatch("residual_cents", out_residual_cents, want_line.residual);
        if (out_last !== want_line.last)
          report_mismatch("last", out_last, want_line.last);
      end
      lines_checked++;
    end
  end

  // greedy walk over the drawer, one expected line per denomination
  task automatic predict_change(input logic mode, input logic [AMT_W-1:0] amount);
    change_line_t line;
    int unsigned  owed;
    int unsigned  pieces;
    owed = 32'(amount);
    if (mode == MODE_REFILL) begin
      owed = 0;
      for (int d = 0; d < DENOMS; d++)
        drawer_stock[d] = CNT_W'(full_stock[d]);
    end
    for (int d = 0; d < DENOMS; d++) begin
      pieces = 0;
      // an empty denomination is skipped
      if (mode == MODE_DISPENSE && drawer_stock[d] != 0) begin
        pieces = owed / coin_cents[d];
        if (pieces > drawer_stock[d])
          pieces = 32'(drawer_stock[d]);
        drawer_stock[d] = drawer_stock[d] - CNT_W'(pieces);
        owed = owed - pieces * coin_cents[d];
      end
      line.idx      = IDX_W'(d);
      line.given    = CNT_W'(pieces);
      line.left     = drawer_stock[d];
      line.residual = AMT_W'(owed);
      line.last     = (d == DENOMS - 1);
      expected_lines.push_back(line);
    end
  endtask

  // offer one transaction, with random idle cycles first
  task automatic send_request(input logic mode, input logic [AMT_W-1:0] amount);
    while ($urandom_range(99) < idle_pct) begin
      in_valid        <= 1'b0;
      in_mode         <= 1'($urandom);
      in_amount_cents <= AMT_W'($urandom);
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_amount_cents <= amount;
    do @(posedge clk); while (in_stall);
    predict_change(mode, amount);
  endtask

  // sender stops until every expected line has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] random_amount();
    int unsigned      pick;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(99);
    if (pick < 15)
      amt = AMT_W'($urandom);
    else if (pick < 55)
      amt = AMT_W'($urandom_range(5000));
    else if (pick < 85)
      amt = AMT_W'($urandom_range(1000000));
    else
      amt = AMT_W'($urandom_range(100000000));
    // mostly payable amounts, some with odd cents
    if ($urandom_range(3) != 0)
      amt = amt - amt % 5;
    return amt;
  endfunction

  // edges of the amount, exact payouts, stock run out and refill
  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(MODE_DISPENSE, 0);
    send_request(MODE_DISPENSE, 5);
    send_request(MODE_DISPENSE, 4);
    send_request(MODE_DISPENSE, 391175);
    send_request(MODE_DISPENSE, 391179);
    send_request(MODE_REFILL, '1);
    send_request(MODE_DISPENSE, 5000000);
    send_request(MODE_DISPENSE, 200000);
    send_request(MODE_DISPENSE, 100000000);
    send_request(MODE_DISPENSE, 1234);
    send_request(MODE_DISPENSE, '1);
    send_request(MODE_REFILL, 0);
    send_request(MODE_REFILL, 12345);
    send_request(MODE_DISPENSE, '1);
    send_request(MODE_REFILL, 0);
    send_request(MODE_DISPENSE, 100000);
  endtask

  // random dispense and refill traffic under one idling setting
  task automatic test_random_traffic(input int count, input int send_idle,
                                     input int recv_stall);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0)
        send_request(MODE_REFILL, random_amount());
      else
        send_request(MODE_DISPENSE, random_amount());
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_request <= hold_request + 1;
    for (int k = 0; k < 6; k++)
      send_request(MODE_DISPENSE, random_amount());
  endtask

  // sender waits for an empty pipeline mid-stream
  task automatic test_pause_for_drain();
    idle_pct  = 33;
    stall_pct = 33;
    send_request(MODE_DISPENSE, random_amount());
    send_request(MODE_REFILL, random_amount());
    pause_until_drained();
    send_request(MODE_DISPENSE, random_amount());
    send_request(MODE_DISPENSE, random_amount());
  endtask

  initial begin
    for (int d = 0; d < DENOMS; d++)
      drawer_stock[d] = CNT_W'(full_stock[d]);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(50, 0, 0);
    test_random_traffic(50, 56, 0);
    test_random_traffic(50, 0, 56);
    test_random_traffic(50, 33, 33);
    test_output_hold();
    test_pause_for_drain();
    pause_until_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
